// File: hdl/ppid_pkg.sv
// ============================================================================
// ppid_pkg: shared types and constants of the positional PID controller
// Register codes, configuration record, fixed widths and a helper function.
// ============================================================================
package ppid_pkg;

    // Default sample width and number of fraction bits in the gains.
    localparam int DATA_WIDTH_DEF     = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Fixed widths of the register file and the result beat.
    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 15;
    localparam int TOL_W     = 16;
    localparam int OUT_W     = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_I   = 3'd1,
        REG_GAIN_D   = 3'd2,
        REG_MAX_OUT  = 3'd3,
        REG_MAX_INT  = 3'd4,
        REG_SEP_TOL  = 3'd5,
        REG_SEP_EN   = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic        [LIMIT_W-1:0] max_out;
        logic        [LIMIT_W-1:0] max_integral;
        logic        [TOL_W-1:0]   separation_tolerance;
        logic                      separation_enable;
    } cfg_t;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// File: hdl/ppid_if.sv
// ============================================================================
// ppid_if: handshake channels of the positional PID controller
// Sample, result and configuration write channels with valid and ready.
// ============================================================================
interface ppid_sample_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] setpoint;
    logic signed [DATA_WIDTH-1:0] measured;

    modport source (output valid, output setpoint, output measured, input ready);
    modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface ppid_result_if;
    import ppid_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] control_output;
    logic                    integral_removed;

    modport source (output valid, output control_output, output integral_removed,
                    input ready);
    modport sink   (input valid, input control_output, input integral_removed,
                    output ready);
endinterface

interface ppid_cfg_if;
    import ppid_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/ppid_step.sv
// ============================================================================
// ppid_step: one control step of the positional PID controller
// Error, clamped integral update, clamped output and integral separation.
// ============================================================================
module ppid_step #(
    parameter int DATA_WIDTH     = ppid_pkg::DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = ppid_pkg::GAIN_FRAC_BITS_DEF
) (
    input  ppid_pkg::cfg_t                                cfg_regs,
    input  logic signed [DATA_WIDTH-1:0]                  setpoint,
    input  logic signed [DATA_WIDTH-1:0]                  measured,
    input  logic signed [ppid_pkg::GAIN_W+GAIN_FRAC_BITS-1:0] accum,
    input  logic signed [DATA_WIDTH:0]                    prev_err,
    output logic signed [ppid_pkg::GAIN_W+GAIN_FRAC_BITS-1:0] accum_next,
    output logic signed [DATA_WIDTH:0]                    err,
    output logic signed [ppid_pkg::OUT_W-1:0]             control_output,
    output logic                                          integral_removed
);
    import ppid_pkg::*;

    localparam int EW    = DATA_WIDTH + 1;
    localparam int INT_W = GAIN_W + GAIN_FRAC_BITS;
    localparam int PW    = GAIN_W + EW;
    localparam int DPW   = GAIN_W + EW + 1;
    localparam int AW    = imax(INT_W, PW) + 1;
    localparam int SUM_W = imax(INT_W, DPW) + 2;
    localparam int CW    = imax(EW, TOL_W);

    logic signed [EW:0]      derr;
    logic signed [PW-1:0]    prod_p;
    logic signed [PW-1:0]    prod_i;
    logic signed [DPW-1:0]   prod_d;
    logic signed [AW-1:0]    acc_sum;
    logic signed [AW-1:0]    ilim;
    logic signed [AW-1:0]    acc_clamped;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] scaled;
    logic signed [SUM_W-1:0] olim;
    logic signed [SUM_W-1:0] out_clamped;
    logic signed [INT_W-1:0] iterm;
    logic signed [OUT_W-1:0] res;
    logic        [CW-1:0]    mag;

    assign err  = EW'(setpoint) - EW'(measured);
    assign derr = (EW+1)'(err) - (EW+1)'(prev_err);

    assign prod_p = PW'(cfg_regs.gain_p) * PW'(err);
    assign prod_i = PW'(cfg_regs.gain_i) * PW'(err);
    assign prod_d = DPW'(cfg_regs.gain_d) * DPW'(derr);

    // The integral limit is given in output units; scale it to the accumulator.
    assign acc_sum = AW'(accum) + AW'(prod_i);
    assign ilim    = $signed(AW'(cfg_regs.max_integral)) <<< GAIN_FRAC_BITS;

    always_comb
    begin
        priority if (acc_sum > ilim)
            acc_clamped = ilim;
        else if (acc_sum < -ilim)
            acc_clamped = -ilim;
        else
            acc_clamped = acc_sum;
    end

    assign accum_next = INT_W'(acc_clamped);

    assign sum    = SUM_W'(prod_p) + SUM_W'(accum_next) + SUM_W'(prod_d);
    assign scaled = sum >>> GAIN_FRAC_BITS;
    assign olim   = $signed(SUM_W'(cfg_regs.max_out));

    always_comb
    begin
        priority if (scaled > olim)
            out_clamped = olim;
        else if (scaled < -olim)
            out_clamped = -olim;
        else
            out_clamped = scaled;
    end

    assign res   = OUT_W'(out_clamped);
    assign iterm = accum_next >>> GAIN_FRAC_BITS;
    assign mag   = (err < 0) ? CW'(-err) : CW'(err);

    assign integral_removed = cfg_regs.separation_enable &&
                              (mag >= CW'(cfg_regs.separation_tolerance));
    assign control_output   = integral_removed ? (res - OUT_W'(iterm)) : res;

endmodule

// File: hdl/positional_pid_with_clamps_top.sv
// ============================================================================
// positional_pid_with_clamps_top: positional PID controller with clamps
// Fixed-point PID step per sample beat with integral clamp, output clamp and
// optional integral separation.
// ============================================================================
// Each sample beat (setpoint, measured) yields exactly one result beat. The
// block takes one sample per clock cycle while the result channel does not
// stall: a beat is held in the input register, the full step (three
// multiplies, the integral clamp, the output clamp and the separation check)
// is evaluated in one pass, and the result lands in the output register. The
// integral and previous-error state is updated in the same cycle the result
// is registered, which is the loop that fixes the rate at one beat per cycle.
// A stalled result holds the output register, and the input register still
// takes one more beat before the sample channel stalls. Gains are signed Q8.8
// by default, the integral is kept with the same number of fraction bits and
// clamped to plus or minus max_integral output units. Configuration beats are
// always accepted and must only be sent while no sample is in flight; an
// unknown register index is dropped. State, the register file and the valid
// flags are cleared by reset; the sample and result data registers are not.
module positional_pid_with_clamps_top #(
    parameter int DATA_WIDTH     = ppid_pkg::DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = ppid_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ppid_sample_if.sink  sample,
    ppid_result_if.source result,
    ppid_cfg_if.sink     cfg
);
    import ppid_pkg::*;

    localparam int EW    = DATA_WIDTH + 1;
    localparam int INT_W = GAIN_W + GAIN_FRAC_BITS;

    // Register file.
    cfg_t cfg_reg;

    // Input register stage.
    logic                         s1_valid_reg;
    logic signed [DATA_WIDTH-1:0] s1_setpoint_reg;
    logic signed [DATA_WIDTH-1:0] s1_measured_reg;

    // Controller state.
    logic signed [INT_W-1:0] accum_reg;
    logic signed [EW-1:0]    prev_err_reg;

    // Result register stage.
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] out_control_reg;
    logic                    out_removed_reg;

    logic signed [INT_W-1:0] accum_next;
    logic signed [EW-1:0]    err;
    logic signed [OUT_W-1:0] step_control;
    logic                    step_removed;
    logic                    advance;
    logic                    take_sample;

    // Configuration writes are taken at any time.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_GAIN_P:  cfg_reg.gain_p               <= cfg.data;
                REG_GAIN_I:  cfg_reg.gain_i               <= cfg.data;
                REG_GAIN_D:  cfg_reg.gain_d               <= cfg.data;
                REG_MAX_OUT: cfg_reg.max_out              <= cfg.data[LIMIT_W-1:0];
                REG_MAX_INT: cfg_reg.max_integral         <= cfg.data[LIMIT_W-1:0];
                REG_SEP_TOL: cfg_reg.separation_tolerance <= cfg.data;
                REG_SEP_EN:  cfg_reg.separation_enable    <= cfg.data[0];
                default:     cfg_reg                      <= cfg_reg;
            endcase
        end
    end

    // The step fires when the input register holds a beat and the result
    // register is free or being emptied this cycle.
    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || advance;
    assign take_sample  = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (sample.ready)
            s1_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            s1_setpoint_reg <= sample.setpoint;
            s1_measured_reg <= sample.measured;
        end
    end

    ppid_step #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_step (
        .cfg_regs         (cfg_reg),
        .setpoint         (s1_setpoint_reg),
        .measured         (s1_measured_reg),
        .accum            (accum_reg),
        .prev_err         (prev_err_reg),
        .accum_next       (accum_next),
        .err              (err),
        .control_output   (step_control),
        .integral_removed (step_removed)
    );

    // State only moves when a step is committed to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg    <= '0;
            prev_err_reg <= '0;
        end
        else if (advance)
        begin
            accum_reg    <= accum_next;
            prev_err_reg <= err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_control_reg <= step_control;
            out_removed_reg <= step_removed;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.control_output   = out_control_reg;
    assign result.integral_removed = out_removed_reg;

endmodule
